[rtl/core/cbm_pkg.sv]
// Package for the cartridge bank mapper: operation and target codes,
// register indexes, field widths and the result record.
// No dependencies.
package cbm_pkg;

    // Number of 1 KB CHR bank registers and the bits to index them.
    localparam int CHR_SLOTS = 8;
    localparam int CHR_IDX_W = $clog2(CHR_SLOTS);

    // Field widths.
    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 8;
    localparam int MAP_W    = 22;
    localparam int SIZE_W   = 9;
    localparam int BANK_W   = 8;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 24;

    // Reset values of the ROM size registers.
    localparam logic [SIZE_W-1:0] PRG_SIZE_RST = 9'd8;
    localparam logic [SIZE_W-1:0] CHR_SIZE_RST = 9'd128;

    // Prescaler masks and nibble fields.
    localparam logic [7:0] MASK_FIRST = 8'h7F;
    localparam logic [7:0] MASK_FULL  = 8'hFF;
    localparam logic [7:0] NIB_LO     = 8'h0F;
    localparam logic [7:0] NIB_HI     = 8'hF0;

    // Register indexes of the configuration port.
    localparam logic CFG_PRG_SIZE = 1'b0;
    localparam logic CFG_CHR_SIZE = 1'b1;

    // Upper address nibbles of the CPU write decoder.
    localparam logic [3:0] NIB_PRG0   = 4'h8;
    localparam logic [3:0] NIB_MIRROR = 4'h9;
    localparam logic [3:0] NIB_PRG1   = 4'hA;
    localparam logic [3:0] NIB_CHR_B  = 4'hB;
    localparam logic [3:0] NIB_CHR_C  = 4'hC;
    localparam logic [3:0] NIB_CHR_D  = 4'hD;
    localparam logic [3:0] NIB_CHR_E  = 4'hE;
    localparam logic [3:0] NIB_IRQ    = 4'hF;

    typedef enum logic [1:0] {
        OP_WRITE    = 2'd0,
        OP_TICK     = 2'd1,
        OP_PRG_READ = 2'd2,
        OP_PPU_READ = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_PRG  = 2'd1,
        KIND_CHR  = 2'd2,
        KIND_NT   = 2'd3
    } t_kind;

    typedef struct packed {
        logic             irq;
        t_kind            kind;
        logic [MAP_W-1:0] addr;
    } t_result;

endpackage

[rtl/core/cartridge_bank_mapper_with_irq.sv]
// Cartridge bank mapper top level: register decode, IRQ prescaler/counter
// and PRG/PPU address translation, with an output register and skid stage.
// Depends on cbm_pkg.
//
// Results are registered, with a skid stage behind for a stalled output.
// Throughput: one item per cycle until the skid stage fills; decode and
// counter update are one combinational pass into the result register. A
// two-entry output (result register plus skid) keeps input ready high while
// one result is stalled. Synchronous active-low reset clears all bank,
// mirroring and IRQ state, empties the output, sets PRG/CHR size to 8/128.
module cartridge_bank_mapper_with_irq
    import cbm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration write port.
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [SIZE_W-1:0]   i_cfg_data,
    // Input items.
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,  // bus_addr[15:0], write_data[23:16]
    input  logic [1:0]          i_s_tuser,  // op[1:0]
    // Result items.
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata,  // irq_asserted[0], mapped_addr[22:1], zero[23]
    output logic [1:0]          o_m_tuser   // target_kind[1:0]
);

    // Configuration and mapper state.
    logic [SIZE_W-1:0] r_prg_size, r_chr_size;
    logic [BANK_W-1:0] r_prg_bank [2];
    logic [BANK_W-1:0] n_prg_bank [2];
    logic [BANK_W-1:0] r_chr_bank [CHR_SLOTS];
    logic [BANK_W-1:0] n_chr_bank [CHR_SLOTS];
    logic              r_nt_horiz, n_nt_horiz;
    logic              r_irq_en, n_irq_en;
    logic [7:0]        r_pre_cnt, n_pre_cnt;
    logic [7:0]        r_pre_mask, n_pre_mask;
    logic [7:0]        r_irq_cnt, n_irq_cnt;
    logic              r_irq_line, n_irq_line;

    // Output register and skid stage.
    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;
    t_result n_res;

    // Decode helpers.
    t_op                  in_op;
    logic [ADDR_W-1:0]    in_addr;
    logic [DATA_W-1:0]    in_data;
    logic [3:0]           nib;
    logic [CHR_IDX_W-1:0] wr_chr_idx;
    logic [CHR_IDX_W-1:0] rd_chr_idx;
    logic [1:0]           chr_pair;
    logic [7:0]           prg_last;
    logic [7:0]           chr_mask;
    logic [7:0]           prg_bank_sel;
    logic [7:0]           pre_inc;
    logic [7:0]           cnt_inc;
    logic [13:0]          ppu_a;
    logic                 nt_page;
    logic                 in_fire, out_fire;

    assign in_op   = t_op'(i_s_tuser);
    assign in_addr = i_s_tdata[ADDR_W-1:0];
    assign in_data = i_s_tdata[ADDR_W+DATA_W-1:ADDR_W];
    assign nib     = in_addr[15:12];
    assign ppu_a   = in_addr[13:0];

    assign in_fire    = i_s_tvalid && o_s_tready;
    assign out_fire   = r_out_valid && i_m_tready;
    assign o_s_tready = !r_skid_valid;

    // Size registers as (banks - 1), with zero acting as one and sizes
    // above 256 acting as 256.
    function automatic logic [7:0] size_m1(input logic [SIZE_W-1:0] v);
        if (v == '0) begin
            return 8'd0;
        end else if (v[SIZE_W-1]) begin
            return 8'hFF;
        end
        return v[7:0] - 8'd1;
    endfunction

    assign prg_last = size_m1(r_prg_size);
    assign chr_mask = size_m1(r_chr_size);

    // CHR register index for a write: pair from the nibble, member from bit 3.
    assign chr_pair   = 2'(nib - NIB_CHR_B);
    assign wr_chr_idx = CHR_IDX_W'({chr_pair, in_addr[3]});
    assign rd_chr_idx = ppu_a[12:10];

    assign prg_bank_sel = in_addr[13] ? r_prg_bank[1] : r_prg_bank[0];
    assign pre_inc      = r_pre_cnt + 8'd1;
    assign cnt_inc      = r_irq_cnt + 8'd1;
    assign nt_page      = r_nt_horiz ? ppu_a[11] : ppu_a[10];

    // Next state and result of the item on the input side.
    always_comb begin
        n_prg_bank = r_prg_bank;
        n_chr_bank = r_chr_bank;
        n_nt_horiz = r_nt_horiz;
        n_irq_en   = r_irq_en;
        n_pre_cnt  = r_pre_cnt;
        n_pre_mask = r_pre_mask;
        n_irq_cnt  = r_irq_cnt;
        n_irq_line = r_irq_line;
        n_res.kind = KIND_NONE;
        n_res.addr = '0;

        unique case (in_op)
            OP_WRITE: begin
                if (in_addr[15]) begin
                    case (nib) inside
                        NIB_PRG0:   n_prg_bank[0] = in_data;
                        NIB_PRG1:   n_prg_bank[1] = in_data;
                        NIB_MIRROR: n_nt_horiz = in_data[0];
                        NIB_CHR_B, NIB_CHR_C, NIB_CHR_D, NIB_CHR_E: begin
                            if (!in_addr[2]) begin
                                n_chr_bank[wr_chr_idx] = (r_chr_bank[wr_chr_idx] & NIB_HI)
                                                       | (in_data & NIB_LO);
                            end else begin
                                n_chr_bank[wr_chr_idx] = (r_chr_bank[wr_chr_idx] & NIB_LO)
                                                       | ((in_data << 4) & NIB_HI);
                            end
                        end
                        default: begin
                            // IRQ control: counter load, or enable and disable.
                            if (!in_addr[3]) begin
                                n_irq_cnt  = in_data;
                                n_irq_line = 1'b0;
                            end else if (in_data[0]) begin
                                n_irq_en = 1'b1;
                            end else begin
                                n_irq_en   = 1'b0;
                                n_pre_cnt  = '0;
                                n_pre_mask = MASK_FIRST;
                                n_irq_line = 1'b0;
                            end
                        end
                    endcase
                end
            end
            OP_TICK: begin
                if (r_irq_en) begin
                    n_pre_cnt = pre_inc;
                    if ((pre_inc & r_pre_mask) == '0) begin
                        n_pre_mask = MASK_FULL;
                        n_irq_cnt  = cnt_inc;
                        n_irq_line = (cnt_inc == '0);
                    end
                end
            end
            OP_PRG_READ: begin
                if (in_addr[15]) begin
                    n_res.kind = KIND_PRG;
                    if (in_addr[14]) begin
                        // Fixed to the last 16 KB bank.
                        n_res.addr = {prg_last, in_addr[13:0]};
                    end else begin
                        n_res.addr = MAP_W'({prg_bank_sel & {prg_last[6:0], 1'b1},
                                             in_addr[12:0]});
                    end
                end
            end
            OP_PPU_READ: begin
                if (!ppu_a[13]) begin
                    n_res.kind = KIND_CHR;
                    n_res.addr = MAP_W'({r_chr_bank[rd_chr_idx] & chr_mask, ppu_a[9:0]});
                end else if (ppu_a[13:8] != 6'h3F) begin
                    n_res.kind = KIND_NT;
                    n_res.addr = MAP_W'({nt_page, ppu_a[9:0]});
                end
            end
        endcase
        n_res.irq = n_irq_line;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_size <= PRG_SIZE_RST;
            r_chr_size <= CHR_SIZE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PRG_SIZE: r_prg_size <= i_cfg_data;
                CFG_CHR_SIZE: r_chr_size <= i_cfg_data;
            endcase
        end
    end

    // Mapper state, updated by each accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_bank <= '{default: '0};
            r_chr_bank <= '{default: '0};
            r_nt_horiz <= 1'b0;
            r_irq_en   <= 1'b0;
            r_pre_cnt  <= '0;
            r_pre_mask <= '0;
            r_irq_cnt  <= '0;
            r_irq_line <= 1'b0;
        end else if (in_fire) begin
            r_prg_bank <= n_prg_bank;
            r_chr_bank <= n_chr_bank;
            r_nt_horiz <= n_nt_horiz;
            r_irq_en   <= n_irq_en;
            r_pre_cnt  <= n_pre_cnt;
            r_pre_mask <= n_pre_mask;
            r_irq_cnt  <= n_irq_cnt;
            r_irq_line <= n_irq_line;
        end
    end

    // Output register with a skid stage behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (out_fire) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end
            end else if (in_fire) begin
                if (!r_out_valid || out_fire) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid && out_fire) begin
            r_out <= r_skid;
        end else if (in_fire && (!r_out_valid || out_fire)) begin
            r_out <= n_res;
        end
        if (in_fire && r_out_valid && !out_fire) begin
            r_skid <= n_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tdata  = {1'b0, r_out.addr, r_out.irq};

    // The skid stage only holds an item behind a full output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage valid with empty output register");

    // An item accepted while the output is stalled lands in the skid stage.
    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_out_valid && !i_m_tready) |=> r_skid_valid)
        else $error("item accepted under stall was not held in the skid stage");

    // Results without a target carry a zero address.
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == KIND_NONE) |-> (o_m_tdata[M_DATA_W-1:1] == '0))
        else $error("result with no target has a nonzero address");

    // Nametable addresses stay within 2 KB and CHR addresses within 256 KB.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == KIND_NT)) |-> (o_m_tdata[M_DATA_W-1:12] == '0))
        else $error("nametable address out of range");

    a_chr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == KIND_CHR)) |-> (o_m_tdata[M_DATA_W-1:19] == '0))
        else $error("CHR address out of range");

endmodule

[sim/tb.sv]
// Testbench for the cartridge bank mapper: directed and random item streams,
// a self-contained bank, mirroring and IRQ predictor, and a result scoreboard.
// Depends on cbm_pkg and cartridge_bank_mapper_with_irq.
module tb
    import cbm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Clock, reset and block ports.
    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic                cfg_idx = CFG_PRG_SIZE;
    logic [SIZE_W-1:0]   cfg_data = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;   // bus_addr[15:0], write_data[23:16]
    logic [1:0]          s_tuser = OP_TICK;  // op[1:0]
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;        // irq_asserted[0], mapped_addr[22:1], zero[23]
    logic [1:0]          m_tuser;        // target_kind[1:0]

    // Predicted mapper state, reset values as after the block's reset.
    logic [SIZE_W-1:0] prg_size = PRG_SIZE_RST;
    logic [SIZE_W-1:0] chr_size = CHR_SIZE_RST;
    logic [BANK_W-1:0] prg_bank [2] = '{default: '0};
    logic [BANK_W-1:0] chr_bank [CHR_SLOTS] = '{default: '0};
    logic              nt_horiz = 1'b0;
    logic              irq_en = 1'b0;
    logic [7:0]        presc_cnt = '0;
    logic [7:0]        presc_mask = '0;
    logic [7:0]        irq_cnt = '0;
    logic              irq_line = 1'b0;

    // Scoreboard.
    t_result expected_results[$];
    int      mismatches = 0;
    int      items_sent = 0;
    int      burst_left = 0;

    // Receiver stall pattern state.
    int          rx_mode = 0;
    int          rx_left = 0;
    logic [7:0]  rx_phase = '0;

    cartridge_bank_mapper_with_irq u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Hard limit on the run time.
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // A size of zero behaves as one bank, anything above 256 as 256.
    function automatic int unsigned clamp_banks(logic [SIZE_W-1:0] v);
        if (v == '0) begin
            return 1;
        end
        if (v > 9'd256) begin
            return 256;
        end
        return 32'(v);
    endfunction

    // Applies one item to the predicted state and returns its result.
    function automatic t_result mapper_predict(t_op op, logic [15:0] addr,
                                               logic [7:0] data);
        t_result     r;
        int unsigned n16;
        int unsigned bank;
        int unsigned slot;
        int unsigned map;
        logic [3:0]  nib;
        logic [13:0] ppu_a;
        r.kind = KIND_NONE;
        map = 0;
        nib = addr[15:12];
        ppu_a = addr[13:0];
        case (op)
            OP_WRITE: begin
                // Writes below 0x8000 do not reach the mapper.
                if (addr[15]) begin
                    case (nib) inside
                        NIB_PRG0: prg_bank[0] = data;
                        NIB_PRG1: prg_bank[1] = data;
                        NIB_MIRROR: nt_horiz = data[0];
                        NIB_CHR_B, NIB_CHR_C, NIB_CHR_D, NIB_CHR_E: begin
                            // Nibble picks the pair, address bit 3 the register.
                            slot = (((nib - NIB_CHR_B) << 1) | addr[3]) & (CHR_SLOTS - 1);
                            if (!addr[2]) begin
                                chr_bank[slot] = (chr_bank[slot] & NIB_HI) | (data & NIB_LO);
                            end else begin
                                chr_bank[slot] = (chr_bank[slot] & NIB_LO) |
                                                 ((data << 4) & NIB_HI);
                            end
                        end
                        default: begin
                            if (!addr[3]) begin
                                irq_cnt = data;
                                irq_line = 1'b0;
                            end else if (data[0]) begin
                                irq_en = 1'b1;
                            end else begin
                                irq_en = 1'b0;
                                presc_cnt = '0;
                                presc_mask = MASK_FIRST;
                                irq_line = 1'b0;
                            end
                        end
                    endcase
                end
            end
            OP_TICK: begin
                // The counter steps each time the masked prescaler comes round.
                if (irq_en) begin
                    presc_cnt = presc_cnt + 8'd1;
                    if ((presc_cnt & presc_mask) == 8'd0) begin
                        presc_mask = MASK_FULL;
                        irq_cnt = irq_cnt + 8'd1;
                        irq_line = (irq_cnt == 8'd0);
                    end
                end
            end
            OP_PRG_READ: begin
                if (addr[15]) begin
                    n16 = clamp_banks(prg_size);
                    r.kind = KIND_PRG;
                    if (addr >= 16'hC000) begin
                        // Upper 16 KB is fixed to the last bank.
                        map = (n16 - 1) * 32'h4000 + addr[13:0];
                    end else begin
                        bank = prg_bank[addr >= 16'hA000] & (n16 * 2 - 1);
                        map = bank * 32'h2000 + addr[12:0];
                    end
                end
            end
            default: begin
                if (ppu_a < 14'h2000) begin
                    bank = chr_bank[ppu_a[12:10]] & (clamp_banks(chr_size) - 1);
                    r.kind = KIND_CHR;
                    map = bank * 32'h400 + ppu_a[9:0];
                end else if (ppu_a < 14'h3F00) begin
                    // Nametables; palette space gives no target.
                    r.kind = KIND_NT;
                    map = (nt_horiz ? ppu_a[11] : ppu_a[10]) * 32'h400 + ppu_a[9:0];
                end
            end
        endcase
        r.irq = irq_line;
        r.addr = map[MAP_W-1:0];
        return r;
    endfunction

    // Sends one item in bursts with random gaps and records its expected result.
    task automatic send_item(t_op op, logic [15:0] addr, logic [7:0] data);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= {data, addr};
        s_tuser <= op;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        expected_results.push_back(mapper_predict(op, addr, data));
        items_sent++;
        burst_left--;
    endtask

    // Stops sending and lets every expected result come back.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes both ROM size registers; the block must be idle.
    task automatic write_sizes(logic [SIZE_W-1:0] prg_v, logic [SIZE_W-1:0] chr_v);
        cfg_we <= 1'b1;
        cfg_idx <= CFG_PRG_SIZE;
        cfg_data <= prg_v;
        @(posedge i_clk);
        cfg_idx <= CFG_CHR_SIZE;
        cfg_data <= chr_v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        prg_size = prg_v;
        chr_size = chr_v;
        @(posedge i_clk);
    endtask

    // Register decode: PRG, mirroring and CHR writes, both CHR nibbles, and a write below 0x8000.
    task automatic test_register_decode();
        send_item(OP_WRITE, 16'h8000, 8'hFF);
        send_item(OP_WRITE, 16'hAFFF, 8'h00);
        send_item(OP_WRITE, 16'h9000, 8'h01);
        send_item(OP_WRITE, 16'hB000, 8'h0F);
        send_item(OP_WRITE, 16'hB004, 8'hFA);
        send_item(OP_WRITE, 16'hEFFC, 8'h5C);
        send_item(OP_WRITE, 16'h7FFF, 8'hFF);
    endtask

    // Translation of PRG and PPU reads over all regions and their edges.
    task automatic test_translation();
        send_item(OP_PRG_READ, 16'h0000, 8'h00);
        send_item(OP_PRG_READ, 16'h8000, 8'h00);
        send_item(OP_PRG_READ, 16'hBFFF, 8'h00);
        send_item(OP_PRG_READ, 16'hC000, 8'h00);
        send_item(OP_PRG_READ, 16'hFFFF, 8'h00);
        send_item(OP_PPU_READ, 16'h0000, 8'h00);
        send_item(OP_PPU_READ, 16'h1FFF, 8'h00);
        send_item(OP_PPU_READ, 16'h2C00, 8'h00);
        send_item(OP_PPU_READ, 16'h3EFF, 8'h00);
        send_item(OP_PPU_READ, 16'h3F00, 8'h00);
        send_item(OP_PPU_READ, 16'hFFFF, 8'h00);
    endtask

    // IRQ: counter wrap raises the line, a count write clears it, disable resets.
    task automatic test_irq_counter();
        send_item(OP_WRITE, 16'hF008, 8'h01);
        send_item(OP_WRITE, 16'hF000, 8'hFF);
        send_item(OP_TICK, 16'h0000, 8'h00);
        send_item(OP_TICK, 16'hFFFF, 8'hFF);
        send_item(OP_WRITE, 16'hF000, 8'hFE);
        send_item(OP_WRITE, 16'hF008, 8'hFE);
        send_item(OP_TICK, 16'h0000, 8'h00);
    endtask

    // One size setting followed by random sequences of items.
    task automatic test_random_phase(logic [SIZE_W-1:0] prg_v, logic [SIZE_W-1:0] chr_v,
                                     int quota);
        int         start_cnt;
        int         sel;
        int         len;
        logic [15:0] a;
        logic [7:0]  d;
        wait_idle();
        write_sizes(prg_v, chr_v);
        start_cnt = items_sent;
        while (items_sent - start_cnt < quota) begin
            sel = $urandom_range(0, 99);
            if (sel < 30) begin
                // Bank setup followed by reads that use it.
                len = $urandom_range(1, 4);
                repeat (len) begin
                    a = 16'($urandom);
                    a[15:12] = 4'($urandom_range(8, 14));
                    d = 8'($urandom);
                    send_item(OP_WRITE, a, d);
                end
                len = $urandom_range(1, 6);
                repeat (len) begin
                    if ($urandom_range(0, 1) == 1) begin
                        a = 16'($urandom);
                        a[15] = ($urandom_range(0, 7) != 0);
                        send_item(OP_PRG_READ, a, 8'($urandom));
                    end else begin
                        a = 16'($urandom_range(0, 16'h3FFF));
                        send_item(OP_PPU_READ, a, 8'($urandom));
                    end
                end
            end else if (sel < 55) begin
                // Reads anywhere in both address spaces.
                len = $urandom_range(2, 10);
                repeat (len) begin
                    a = 16'($urandom);
                    send_item($urandom_range(0, 1) ? OP_PRG_READ : OP_PPU_READ, a,
                              8'($urandom));
                end
            end else if (sel < 80) begin
                // IRQ setup, mostly near the wrap point, then a run of ticks.
                if ($urandom_range(0, 1) == 1) begin
                    a = 16'($urandom);
                    a[15:12] = NIB_IRQ;
                    a[3] = 1'b0;
                    d = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                    : 8'hFF - 8'($urandom_range(0, 2));
                    send_item(OP_WRITE, a, d);
                end
                if ($urandom_range(0, 2) == 0) begin
                    a = 16'($urandom);
                    a[15:12] = NIB_IRQ;
                    a[3] = 1'b1;
                    d = 8'($urandom);
                    d[0] = ($urandom_range(0, 4) != 0);
                    send_item(OP_WRITE, a, d);
                end
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 280)
                                                   : $urandom_range(1, 24);
                repeat (len) begin
                    a = 16'($urandom);
                    if ($urandom_range(0, 7) == 0) begin
                        send_item(OP_PPU_READ, a, 8'($urandom));
                    end else begin
                        send_item(OP_TICK, a, 8'($urandom));
                    end
                end
            end else begin
                // Noise: any operation with any address and data.
                len = $urandom_range(1, 6);
                repeat (len) begin
                    send_item(t_op'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
                end
            end
        end
    endtask

    // Receiver: ready follows a randomly chosen mode that is redrawn when its countdown runs out.
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(16, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (rx_phase[1:0] == 2'd0);
            default: m_tready <= ($urandom_range(0, 9) == 0) ? ~m_tready : m_tready;
        endcase
        rx_phase <= rx_phase + 8'd1;
    end

    // Compares each accepted result with the oldest expected one.
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                if (mismatches < 10) begin
                    $display("unexpected result: tdata %h tuser %h", m_tdata, m_tuser);
                end
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[0] !== want.irq || m_tuser !== want.kind ||
                    m_tdata[MAP_W:1] !== want.addr) begin
                    if (mismatches < 10) begin
                        $display({"mismatch: expected irq %0d kind %0d addr %h, ",
                                  "got irq %0d kind %0d addr %h"},
                                 want.irq, want.kind, want.addr,
                                 m_tdata[0], m_tuser, m_tdata[MAP_W:1]);
                    end
                    mismatches++;
                end
            end
        end
    end

    // Test sequence.
    initial begin
        int drain;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_register_decode();
        test_translation();
        test_irq_counter();
        test_random_phase(PRG_SIZE_RST, CHR_SIZE_RST, 110);
        test_random_phase(9'd0, 9'd0, 110);
        test_random_phase(9'd1, 9'd1, 110);
        test_random_phase(9'd256, 9'd256, 110);
        test_random_phase(9'd511, 9'd511, 110);
        test_random_phase(9'd257, 9'd300, 110);
        test_random_phase(9'd3, 9'd100, 110);
        test_random_phase(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)), 110);

        // Drain the pipeline, then give the output stage time to settle.
        s_tvalid <= 1'b0;
        drain = 0;
        while (expected_results.size() != 0 && drain < 100000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (8) @(posedge i_clk);
        mismatches += expected_results.size();
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
